FILE: hdl/rmad_pkg.sv
// Shared types, constants and the luma function for the mono dither block.
package rmad_pkg;

   localparam int CSR_DATA_WIDTH  = 10;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_HEIGHT = 2'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] DIM_RESET = 10'd200;

   localparam logic [7:0] LUMA_R = 8'd77;
   localparam logic [7:0] LUMA_G = 8'd150;
   localparam logic [7:0] LUMA_B = 8'd29;

   localparam logic signed [9:0] THRESHOLD   = 10'sd128;
   localparam logic signed [9:0] WHITE_LEVEL = 10'sd255;

   // one error store entry: complete error for the next row, share for the row after
   typedef struct packed {
      logic signed [6:0] nre;
      logic signed [4:0] sre;
   } err_entry_type;

   // geometry flags of one pixel position
   typedef struct packed {
      logic last_col;
      logic last;
      logic right1;
      logic right2;
      logic below1;
      logic below2;
   } geo_flags_type;

   function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [17:0] sum;
      sum = 18'(LUMA_R) * 18'(r) + 18'(LUMA_G) * 18'(g) + 18'(LUMA_B) * 18'(b);
      return sum[15:8];
   endfunction

endpackage

FILE: hdl/rmad_err_ram.sv
// Error store: one write port, one registered read port.
module rmad_err_ram
   import rmad_pkg::*;
#(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  err_entry_type wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output err_entry_type rd_data
);

   err_entry_type mem [DEPTH];
   err_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rmad_raster.sv
// Geometry registers, raster position counters and per-position flags.
module rmad_raster
   import rmad_pkg::*;
#(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512,
   parameter int CW         = 9,
   parameter int RW         = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                       advance,
   output logic [CW-1:0]              pos_x,
   output logic [RW-1:0]              pos_y,
   output geo_flags_type              flags
);

   localparam int WD = $clog2(MAX_WIDTH + 1) + 1;
   localparam int HD = $clog2(MAX_HEIGHT + 1) + 1;

   logic [CSR_DATA_WIDTH-1:0] width_ff, height_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [WD-1:0] w_eff, x1, x2;
   logic [HD-1:0] h_eff, y1, y2;
   logic restart;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WD'(1);
      end else if (width_ff > MAX_WIDTH) begin
         w_eff = WD'(MAX_WIDTH);
      end else begin
         w_eff = WD'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HD'(1);
      end else if (height_ff > MAX_HEIGHT) begin
         h_eff = HD'(MAX_HEIGHT);
      end else begin
         h_eff = HD'(height_ff);
      end
   end

   // geometry shrunk under the counters: start again at the origin
   assign restart = (WD'(col_ff) >= w_eff) || (HD'(row_ff) >= h_eff);
   assign pos_x   = restart ? '0 : col_ff;
   assign pos_y   = restart ? '0 : row_ff;

   assign x1 = WD'(pos_x) + WD'(1);
   assign x2 = WD'(pos_x) + WD'(2);
   assign y1 = HD'(pos_y) + HD'(1);
   assign y2 = HD'(pos_y) + HD'(2);

   always_comb begin
      flags.last_col = (x1 == w_eff);
      flags.last     = (x1 == w_eff) && (y1 == h_eff);
      flags.right1   = (x1 < w_eff);
      flags.right2   = (x2 < w_eff);
      flags.below1   = (y1 < h_eff);
      flags.below2   = (y2 < h_eff);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (flags.last_col) begin
            col_in = '0;
            row_in = flags.last ? '0 : RW'(y1);
         end else begin
            col_in = CW'(x1);
            row_in = pos_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_IMAGE_WIDTH:  width_ff  <= csr_write_data;
               REG_IMAGE_HEIGHT: height_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: hdl/rmad_diffuse.sv
// Threshold and Atkinson error split; holds the in-row error registers.
module rmad_diffuse
   import rmad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  logic          x_zero,
   input  geo_flags_type flags,
   input  logic [7:0]    luma,
   input  err_entry_type rd_entry,
   output logic          white,
   output err_entry_type wr_left,
   output err_entry_type wr_here
);

   logic signed [5:0] pr1_ff, pr1_in, pr1_use;
   logic signed [4:0] pr2_ff, pr2_in, pr2_use;
   logic signed [4:0] pd1_ff, pd1_use;
   logic signed [4:0] pd2_ff, pd2_use;
   logic signed [4:0] sec_prev_ff;
   logic signed [9:0] val;
   logic signed [8:0] err, bias, dq;
   logic signed [4:0] d;

   // row start: the in-row registers are zero by definition
   assign pr1_use = x_zero ? '0 : pr1_ff;
   assign pr2_use = x_zero ? '0 : pr2_ff;
   assign pd1_use = x_zero ? '0 : pd1_ff;
   assign pd2_use = x_zero ? '0 : pd2_ff;

   always_comb begin
      val   = $signed({2'b00, luma}) + 10'(rd_entry.nre) + 10'(pr1_use);
      white = (val >= THRESHOLD);
      err   = white ? 9'(val - WHITE_LEVEL) : 9'(val);
      // divide by eight, truncating toward zero
      bias  = err[8] ? 9'sd7 : 9'sd0;
      dq    = (err + bias) >>> 3;
      d     = 5'(dq);

      pr1_in = flags.right1 ? 6'(pr2_use) + 6'(d) : '0;
      pr2_in = flags.right2 ? d : '0;

      wr_left.nre = flags.below1 ?
                    7'(pd2_use) + 7'(pd1_use) + 7'(d) + 7'(sec_prev_ff) : '0;
      wr_left.sre = flags.below2 ? pd1_use : '0;
      wr_here.nre = flags.below1 ? 7'(pd1_use) + 7'(d) + 7'(rd_entry.sre) : '0;
      wr_here.sre = flags.below2 ? d : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr1_ff      <= '0;
         pr2_ff      <= '0;
         pd1_ff      <= '0;
         pd2_ff      <= '0;
         sec_prev_ff <= '0;
      end else if (fire) begin
         pr1_ff      <= pr1_in;
         pr2_ff      <= pr2_in;
         pd2_ff      <= pd1_use;
         pd1_ff      <= d;
         sec_prev_ff <= rd_entry.sre;
      end
   end

endmodule

FILE: hdl/rgb_to_mono_atkinson_dither_top.sv
// An accepted word is read from the store into stage B, decided, then registered on rsp.
// Throughput: one pixel per clock unless rsp stalls; store read once, written once per cycle.
// Reset: synchronous; afterwards all MAX_WIDTH error store entries are swept to zero,
// during which req_ready is low. CSR writes are taken throughout.
// Geometry resets to 200 x 200.
// Top level: RGB888 stream to 1-bit pixels with Atkinson error diffusion.
module rgb_to_mono_atkinson_dither_top
   import rmad_pkg::*;
#(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_red,
   input  logic [7:0]                 req_green,
   input  logic [7:0]                 req_blue,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [8:0]                 rsp_column,
   output logic [8:0]                 rsp_row,
   output logic                       rsp_white,
   output logic                       rsp_frame_end,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   // ---------------------------------------------------------------
   // Handshake: stage 0 is the accept edge (position, luma, store read);
   // stage B decides the pixel and writes the store; then the rsp register.
   // ---------------------------------------------------------------
   logic req_fire, sb_fire;
   logic sb_valid_ff;
   logic rsp_valid_ff;
   logic clr_busy_ff;
   logic [CW-1:0] clr_addr_ff;

   assign sb_fire   = sb_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_busy_ff && (!sb_valid_ff || sb_fire);
   assign req_fire  = req_valid && req_ready;

   // raster position of the word being accepted
   logic [CW-1:0] pos_x;
   logic [RW-1:0] pos_y;
   geo_flags_type pos_flags;

   rmad_raster #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .CW        (CW),
      .RW        (RW)
   ) u_raster (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .advance         (req_fire),
      .pos_x           (pos_x),
      .pos_y           (pos_y),
      .flags           (pos_flags)
   );

   // stage B registers
   logic [CW-1:0] sb_x_ff;
   logic [RW-1:0] sb_y_ff;
   geo_flags_type sb_flags_ff;
   logic [7:0]    sb_luma_ff;
   logic          byp_valid_ff;
   err_entry_type byp_data_ff;

   // deferred write of the last column's own entry; always lands in the cycle after it is
   // created, when stage B holds a column-zero pixel or nothing
   logic          dfr_valid_ff;
   logic [CW-1:0] dfr_addr_ff;
   err_entry_type dfr_data_ff;

   err_entry_type rd_data, rd_entry, wr_left, wr_here;
   logic          sb_white;

   // store write port: clearing sweep, left neighbour, then deferred entry
   logic          we;
   logic [CW-1:0] waddr;
   err_entry_type wdata;
   logic          left_write, dfr_create;

   assign left_write = sb_fire && (sb_x_ff != '0);
   assign dfr_create = sb_fire && sb_flags_ff.last_col;

   always_comb begin
      priority if (clr_busy_ff) begin
         we    = 1'b1;
         waddr = clr_addr_ff;
         wdata = '0;
      end else if (left_write) begin
         we    = 1'b1;
         waddr = sb_x_ff - CW'(1);
         wdata = wr_left;
      end else if (dfr_valid_ff) begin
         we    = 1'b1;
         waddr = dfr_addr_ff;
         wdata = dfr_data_ff;
      end else begin
         we    = 1'b0;
         waddr = dfr_addr_ff;
         wdata = dfr_data_ff;
      end
   end

   rmad_err_ram #(
      .DEPTH(MAX_WIDTH),
      .AW   (CW)
   ) u_err_ram (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(waddr),
      .wr_data(wdata),
      .rd_en  (req_fire),
      .rd_addr(pos_x),
      .rd_data(rd_data)
   );

   // read that collides with a write at the same edge takes the new word;
   // the deferred entry being created is newest
   err_entry_type byp_in;
   logic          byp_hit;

   always_comb begin
      priority if (dfr_create && (sb_x_ff == pos_x)) begin
         byp_hit = 1'b1;
         byp_in  = wr_here;
      end else if (we && (waddr == pos_x)) begin
         byp_hit = 1'b1;
         byp_in  = wdata;
      end else begin
         byp_hit = 1'b0;
         byp_in  = wdata;
      end
   end

   assign rd_entry = byp_valid_ff ? byp_data_ff : rd_data;

   rmad_diffuse u_diffuse (
      .clock   (clock),
      .reset   (reset),
      .fire    (sb_fire),
      .x_zero  (sb_x_ff == '0),
      .flags   (sb_flags_ff),
      .luma    (sb_luma_ff),
      .rd_entry(rd_entry),
      .white   (sb_white),
      .wr_left (wr_left),
      .wr_here (wr_here)
   );

   // output register
   logic [8:0] rsp_column_ff, rsp_row_ff;
   logic       rsp_white_ff, rsp_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         dfr_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
      end else begin
         // clearing sweep after reset
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + CW'(1);
            if (clr_addr_ff == CW'(MAX_WIDTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end

         if (req_fire) begin
            sb_valid_ff  <= 1'b1;
            byp_valid_ff <= byp_hit;
         end else if (sb_fire) begin
            sb_valid_ff  <= 1'b0;
         end

         if (dfr_create) begin
            dfr_valid_ff <= 1'b1;
         end else if (!clr_busy_ff && !left_write) begin
            dfr_valid_ff <= 1'b0;
         end

         if (sb_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sb_x_ff     <= pos_x;
         sb_y_ff     <= pos_y;
         sb_flags_ff <= pos_flags;
         sb_luma_ff  <= luma_of(req_red, req_green, req_blue);
         byp_data_ff <= byp_in;
      end
      if (dfr_create) begin
         dfr_addr_ff <= sb_x_ff;
         dfr_data_ff <= wr_here;
      end
      if (sb_fire) begin
         rsp_column_ff    <= 9'(sb_x_ff);
         rsp_row_ff       <= 9'(sb_y_ff);
         rsp_white_ff     <= sb_white;
         rsp_frame_end_ff <= sb_flags_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_column    = rsp_column_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_white     = rsp_white_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // a waiting deferred write never meets a left-neighbour write
   a_dfr_port_free: assert property (@(posedge clock) disable iff (reset)
      dfr_valid_ff |-> !left_write)
      else $error("deferred store write collides with left-neighbour write");

   // the deferred write lands in the very next cycle unless renewed
   a_dfr_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (dfr_valid_ff && !dfr_create) |=> !dfr_valid_ff)
      else $error("deferred store write held longer than one cycle");

   // no pixel in flight while the store is being swept
   a_no_pixel_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (!sb_valid_ff && !req_fire))
      else $error("pixel in flight during store clearing");

endmodule

FILE: sim/tb_rgb_to_mono_atkinson_dither_top.sv
// Self-checking testbench for the RGB to mono Atkinson dither top: directed rows, then random frames.
module tb_rgb_to_mono_atkinson_dither_top;
   import rmad_pkg::*;

   // must match the block's default parameters
   localparam int IMG_MAX_W = 512;
   localparam int IMG_MAX_H = 512;

   // one decided pixel as it leaves on the rsp channel
   typedef struct packed {
      logic [8:0] column;
      logic [8:0] row;
      logic       white;
      logic       frame_end;
   } pixel_type;

   localparam pixel_type NO_WANT = '0;

   typedef enum bit {STEP_PIXEL, STEP_GEOM} step_kind_type;

   // one row of the directed part: a pixel word, or a new geometry
   typedef struct {
      step_kind_type kind;
      logic [7:0]    red;
      logic [7:0]    green;
      logic [7:0]    blue;
      logic [9:0]    width;
      logic [9:0]    height;
      bit            lit;
      pixel_type     want;
   } step_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [7:0]                 req_red;
   logic [7:0]                 req_green;
   logic [7:0]                 req_blue;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [8:0]                 rsp_column;
   logic [8:0]                 rsp_row;
   logic                       rsp_white;
   logic                       rsp_frame_end;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   // predictor state: diffused error for the next row and the row after,
   // error carried to the right, d of the last two pixels, raster position
   int            row1_err [IMG_MAX_W];
   int            row2_err [IMG_MAX_W];
   int            right1_err;
   int            right2_err;
   int            d_prev1;
   int            d_prev2;
   int            x_pos;
   int            y_pos;
   logic [9:0]    geom_w;
   logic [9:0]    geom_h;

   pixel_type     awaited_pixels [$];
   int            mismatch_count;
   bit            source_quiet;
   int            pixels_sent;

   rgb_to_mono_atkinson_dither_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_white        (rsp_white),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // Register value as the block uses it: zero acts as one, above the top acts as the top.
   function automatic int clamp_dim(input logic [9:0] v, input int top);
      if (v == 0) return 1;
      if (int'(v) > top) return top;
      return int'(v);
   endfunction

   // Decide one pixel and diffuse its error, exactly as the block should.
   function automatic pixel_type dither_predict(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
      int        w;
      int        h;
      int        x;
      int        y;
      int        luma;
      int        level;
      int        err;
      int        d;
      bit        last_col;
      bit        last;
      bit        is_white;
      pixel_type res;
      w = clamp_dim(geom_w, IMG_MAX_W);
      h = clamp_dim(geom_h, IMG_MAX_H);
      // geometry shrank under the current position: restart the frame,
      // the row stores keep whatever stale error they hold
      if (x_pos >= w || y_pos >= h) begin
         x_pos = 0;
         y_pos = 0;
         right1_err = 0;
         right2_err = 0;
         d_prev1 = 0;
         d_prev2 = 0;
      end
      x = x_pos;
      y = y_pos;
      last_col = (x + 1 == w);
      last = last_col && (y + 1 == h);

      luma = (77 * int'(r) + 150 * int'(g) + 29 * int'(b)) >> 8;
      level = luma + row1_err[x] + right1_err;
      is_white = (level >= 128);
      err = is_white ? level - 255 : level;
      d = err / 8;  // truncates toward zero

      right1_err = (x + 1 < w) ? right2_err + d : 0;
      right2_err = (x + 2 < w) ? d : 0;
      if (x > 0) begin
         row1_err[x-1] = (y + 1 < h) ? d_prev2 + d_prev1 + d + row2_err[x-1] : 0;
         row2_err[x-1] = (y + 2 < h) ? d_prev1 : 0;
      end
      if (last_col) begin
         row1_err[x] = (y + 1 < h) ? d_prev1 + d + row2_err[x] : 0;
         row2_err[x] = (y + 2 < h) ? d : 0;
      end
      d_prev2 = d_prev1;
      d_prev1 = d;

      res.column    = 9'(x);
      res.row       = 9'(y);
      res.white     = is_white;
      res.frame_end = last;

      if (last_col) begin
         right1_err = 0;
         right2_err = 0;
         d_prev1 = 0;
         d_prev2 = 0;
         x_pos = 0;
         y_pos = last ? 0 : y + 1;
      end else begin
         x_pos = x + 1;
      end
      return res;
   endfunction

   // Offer one pixel word after a random gap; the expectation is queued at acceptance.
   // A typed-in result, where given, stands in for the predicted one.
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input bit lit, input pixel_type want);
      int        pick;
      int        gap;
      pixel_type predicted;
      pick = $urandom_range(0, 99);
      if (source_quiet || pick < 55) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = dither_predict(r, g, b);
      awaited_pixels.push_back(lit ? want : predicted);
      pixels_sent++;
   endtask

   // New geometry, written only once the block has drained.
   task automatic set_geometry(input logic [9:0] w, input logic [9:0] h);
      req_valid <= 1'b0;
      while (awaited_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);  // idle clock edges before the write
      csr_write_enable <= 1'b1;
      csr_index        <= REG_IMAGE_WIDTH;
      csr_write_data   <= w;
      @(posedge clock);
      csr_index        <= REG_IMAGE_HEIGHT;
      csr_write_data   <= h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      geom_w = w;
      geom_h = h;
   endtask

   // Result side back-pressure: runs of stall and of ready, now and then a long one.
   initial begin
      int pick;
      int stall;
      int run;
      rsp_ready = 1'b0;
      forever begin
         pick = $urandom_range(0, 99);
         if (pick < 10) stall = $urandom_range(20, 60);
         else if (pick < 40) stall = $urandom_range(1, 4);
         else stall = 0;
         run = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         repeat (stall) begin
            @(posedge clock);
            rsp_ready <= 1'b0;
         end
         repeat (run) begin
            @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every accepted result word against the oldest expectation.
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_pixels.size() == 0) begin
            $display("%0t: unexpected result: column %0d row %0d white %0d frame_end %0d",
                     $time, rsp_column, rsp_row, rsp_white, rsp_frame_end);
            mismatch_count++;
         end else begin
            want = awaited_pixels.pop_front();
            if (rsp_column !== want.column) begin
               $display("%0t: column expected %0d got %0d", $time, want.column, rsp_column);
               mismatch_count++;
            end
            if (rsp_row !== want.row) begin
               $display("%0t: row expected %0d got %0d", $time, want.row, rsp_row);
               mismatch_count++;
            end
            if (rsp_white !== want.white) begin
               $display("%0t: white expected %0d got %0d at (%0d,%0d)",
                        $time, want.white, rsp_white, want.column, want.row);
               mismatch_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $display("%0t: frame_end expected %0d got %0d at (%0d,%0d)",
                        $time, want.frame_end, rsp_frame_end, want.column, want.row);
               mismatch_count++;
            end
         end
      end
   end

   // Hard stop, well beyond the slowest legal run (worst gaps and stalls on every word).
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      step_type   directed_steps [26];
      int         phase_pick;
      int         frame_px;
      int         word_count;
      int         colour_pick;
      int         drain;
      logic [9:0] w_req;
      logic [9:0] h_req;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;

      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_red          = '0;
      req_green        = '0;
      req_blue         = '0;
      csr_write_enable = 1'b0;
      csr_index        = REG_IMAGE_WIDTH;
      csr_write_data   = '0;
      geom_w           = DIM_RESET;
      geom_h           = DIM_RESET;
      mismatch_count   = 0;
      pixels_sent      = 0;
      source_quiet     = 1'b0;

      // Directed rows. Typed-in results only where obvious: first two pixels after
      // reset, and a 1x1 frame where every store has already been flushed to zero.
      directed_steps = '{
         // default 200x200: black then full white with no error to carry
         '{STEP_PIXEL, 8'd0,   8'd0,   8'd0,   10'd0, 10'd0, 1'b1, '{9'd0, 9'd0, 1'b0, 1'b0}},
         '{STEP_PIXEL, 8'd255, 8'd255, 8'd255, 10'd0, 10'd0, 1'b1, '{9'd1, 9'd0, 1'b1, 1'b0}},
         '{STEP_PIXEL, 8'd255, 8'd0,   8'd0,   10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd0,   8'd255, 8'd0,   10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd0,   8'd0,   8'd255, 10'd0, 10'd0, 1'b0, NO_WANT},
         // zero registers act as 1x1; position is outside, so the frame restarts
         '{STEP_GEOM,  8'd0,   8'd0,   8'd0,   10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd200, 8'd10,  8'd90,  10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd255, 8'd255, 8'd255, 10'd0, 10'd0, 1'b1, '{9'd0, 9'd0, 1'b1, 1'b1}},
         '{STEP_PIXEL, 8'd0,   8'd0,   8'd0,   10'd0, 10'd0, 1'b1, '{9'd0, 9'd0, 1'b0, 1'b1}},
         // width above the top acts as 512; greys either side of the threshold
         '{STEP_GEOM,  8'd0,   8'd0,   8'd0,   10'd1023, 10'd2, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd128, 8'd128, 8'd128, 10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd127, 8'd127, 8'd127, 10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd1,   8'd2,   8'd3,   10'd0, 10'd0, 1'b0, NO_WANT},
         // shrink mid-row to 3x3, then one whole frame up to its end mark
         '{STEP_GEOM,  8'd0,   8'd0,   8'd0,   10'd3, 10'd3, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd255, 8'd255, 8'd255, 10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd0,   8'd0,   8'd0,   10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd100, 8'd100, 8'd100, 10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd170, 8'd60,  8'd250, 10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd128, 8'd128, 8'd128, 10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd30,  8'd220, 8'd15,  10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd255, 8'd128, 8'd0,   10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd64,  8'd64,  8'd64,  10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd140, 8'd140, 8'd140, 10'd0, 10'd0, 1'b0, NO_WANT},
         // largest width exactly, height above the top
         '{STEP_GEOM,  8'd0,   8'd0,   8'd0,   10'd512, 10'd1023, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd17,  8'd34,  8'd51,  10'd0, 10'd0, 1'b0, NO_WANT},
         '{STEP_PIXEL, 8'd250, 8'd250, 8'd5,   10'd0, 10'd0, 1'b0, NO_WANT}
      };

      // reset once; afterwards req_ready stays low while the store is swept
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_GEOM) begin
            set_geometry(directed_steps[i].width, directed_steps[i].height);
         end else begin
            send_pixel(directed_steps[i].red, directed_steps[i].green, directed_steps[i].blue,
                       directed_steps[i].lit, directed_steps[i].want);
         end
      end

      // Random phases: a geometry, then mostly whole frames so the diffusion runs
      // deep, sometimes a part frame so the next geometry lands mid-frame.
      pixels_sent = 0;
      while (pixels_sent < 1500) begin
         phase_pick = $urandom_range(0, 9);
         if (phase_pick <= 6) begin
            w_req = 10'($urandom_range(1, 16));
            h_req = 10'($urandom_range(1, 8));
         end else if (phase_pick == 7) begin
            // wide single row: upper column bits
            w_req = 10'($urandom_range(257, 512));
            h_req = 10'd1;
         end else if (phase_pick == 8) begin
            // tall single column: upper row bits
            w_req = 10'd1;
            h_req = 10'($urandom_range(257, 512));
         end else begin
            // out-of-range register values
            case ($urandom_range(0, 3))
               0: begin
                  w_req = 10'd0;
                  h_req = 10'($urandom_range(1, 8));
               end
               1: begin
                  w_req = 10'($urandom_range(513, 1023));
                  h_req = 10'd1;
               end
               2: begin
                  w_req = 10'($urandom_range(1, 16));
                  h_req = 10'd0;
               end
               default: begin
                  w_req = 10'd1;
                  h_req = 10'($urandom_range(513, 1023));
               end
            endcase
         end
         frame_px = clamp_dim(w_req, IMG_MAX_W) * clamp_dim(h_req, IMG_MAX_H);
         if (frame_px <= 128) begin
            word_count = $urandom_range(1, 3) * frame_px;
            if (frame_px > 1 && $urandom_range(0, 3) == 0)
               word_count += $urandom_range(1, frame_px - 1);
         end else if ($urandom_range(0, 2) == 0) begin
            word_count = $urandom_range(1, frame_px - 1);
         end else begin
            word_count = frame_px;
         end
         // keep the total close to the planned word count
         if (word_count > 1500 - pixels_sent) word_count = 1500 - pixels_sent;
         source_quiet = ($urandom_range(0, 3) == 0);  // some phases run back to back
         set_geometry(w_req, h_req);

         repeat (word_count) begin
            colour_pick = $urandom_range(0, 9);
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            if (colour_pick >= 5 && colour_pick <= 7) begin
               g = r;  // plain grey
               b = r;
            end else if (colour_pick == 8) begin
               r = 8'($urandom_range(120, 136));  // grey close to the threshold
               g = r;
               b = r;
            end else if (colour_pick == 9) begin
               r = {8{r[0]}};  // saturated corners
               g = {8{g[0]}};
               b = {8{b[0]}};
            end
            send_pixel(r, g, b, 1'b0, NO_WANT);
         end
      end
      req_valid <= 1'b0;

      // let the last words drain, bounded so a lost result still ends the run
      drain = 0;
      while (awaited_pixels.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (awaited_pixels.size() != 0) begin
         $display("%0t: %0d expected results never arrived, oldest at (%0d,%0d)", $time,
                  awaited_pixels.size(), awaited_pixels[0].column, awaited_pixels[0].row);
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/rmad_pkg.sv
hdl/rmad_err_ram.sv
hdl/rmad_raster.sv
hdl/rmad_diffuse.sv
hdl/rgb_to_mono_atkinson_dither_top.sv
sim/tb_rgb_to_mono_atkinson_dither_top.sv
